@@ rtl/ptc_pkg.sv @@
// ----------------------------------------------------------------------------
// ptc_pkg: shared definitions of the pressure and temperature compensation
// Word widths and register indexes used by the datapath and its divider.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned RAW_W    = 20;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned CFG_AW   = 5;
  // Divider sideband: fine, centi, invalid flag, post-shift flag.
  localparam int unsigned SIDE_W   = 2 * WORD_W + 2;

  typedef enum logic [1:0] {
    REG_TEMP_CAL   = 2'd0,
    REG_PRESS_LOW  = 2'd1,
    REG_PRESS_HIGH = 2'd2,
    REG_PRESS_LAST = 2'd3
  } reg_idx_t;

endpackage

@@ rtl/ptc_div.sv @@
// ----------------------------------------------------------------------------
// ptc_div: pipelined unsigned restoring divider
// One quotient bit per stage, MSB first; an enable stalls every stage at once.
// ----------------------------------------------------------------------------
module ptc_div #(
  parameter int unsigned W  = ptc_pkg::WORD_W,
  parameter int unsigned SW = ptc_pkg::SIDE_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  dividend,
  input  logic [W-1:0]  divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [W-1:0]  quotient,
  output logic [SW-1:0] side_out
);
  import ptc_pkg::*;

  logic          v_r [W];
  logic [W-1:0]  n_r [W];
  logic [W-1:0]  rem_r [W];
  logic [W-1:0]  d_r [W];
  logic [SW-1:0] s_r [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic          v_cur;
    logic [W-1:0]  n_cur;
    logic [W-1:0]  rem_cur;
    logic [W-1:0]  d_cur;
    logic [SW-1:0] s_cur;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_cur   = in_valid;
      assign n_cur   = dividend;
      assign rem_cur = '0;
      assign d_cur   = divisor;
      assign s_cur   = side_in;
    end else begin : g_next
      assign v_cur   = v_r[k-1];
      assign n_cur   = n_r[k-1];
      assign rem_cur = rem_r[k-1];
      assign d_cur   = d_r[k-1];
      assign s_cur   = s_r[k-1];
    end

    assign trial = {rem_cur, n_cur[W-1]};
    assign diff  = trial - {1'b0, d_cur};
    assign ge    = ~diff[W];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_cur;
      end
    end

    // The dividend shifts out at the top while quotient bits enter below.
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]   <= {n_cur[W-2:0], ge};
        rem_r[k] <= ge ? diff[W-1:0] : trial[W-1:0];
        d_r[k]   <= d_cur;
        s_r[k]   <= s_cur;
      end
    end
  end

  assign out_valid = v_r[W-1];
  assign quotient  = n_r[W-1];
  assign side_out  = s_r[W-1];

endmodule

@@ rtl/pressure_temperature_compensation.sv @@
// ----------------------------------------------------------------------------
// pressure_temperature_compensation: 32-bit integer sensor compensation
// Fine temperature, centidegrees and pascals from raw 20-bit readings.
// ----------------------------------------------------------------------------
// A pair of readings is taken on every cycle in which the output side can
// move, so the block sustains one transfer per clock. Each pair passes
// through seven arithmetic stages with no more than one 32-bit multiply on
// any path, the 32-stage divider that produces one quotient bit per stage,
// and three correction stages before its result appears. The whole pipeline
// stalls together while a result waits on the output. Calibration must be
// written through the register port only while no readings are in flight;
// the block itself does not enforce this.
module pressure_temperature_compensation (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: raw_temperature [19:0], raw_pressure [39:20]
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [39:0]                 in_tdata,
  // out_tdata: fine_temperature [31:0], temperature_centi [63:32],
  // pressure_pascal [95:64]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [95:0]                 out_tdata,
  // out_tuser: pressure_invalid [0]
  output logic [0:0]                  out_tuser,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ptc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [ptc_pkg::CFG_W-1:0]   cfg_pwdata,
  output logic [ptc_pkg::CFG_W-1:0]   cfg_prdata,
  output logic                        cfg_pready
);
  import ptc_pkg::*;

  // Configuration registers
  logic [47:0] tcal_r;
  logic [63:0] plow_r;
  logic [63:0] phigh_r;
  logic [15:0] p9cal_r;
  reg_idx_t    cfg_idx;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:3]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcal_r  <= '0;
      plow_r  <= '0;
      phigh_r <= '0;
      p9cal_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_idx)
        REG_TEMP_CAL:   tcal_r  <= cfg_pwdata[47:0];
        REG_PRESS_LOW:  plow_r  <= cfg_pwdata;
        REG_PRESS_HIGH: phigh_r <= cfg_pwdata;
        REG_PRESS_LAST: p9cal_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TEMP_CAL:   cfg_prdata = {16'd0, tcal_r};
      REG_PRESS_LOW:  cfg_prdata = plow_r;
      REG_PRESS_HIGH: cfg_prdata = phigh_r;
      REG_PRESS_LAST: cfg_prdata = {48'd0, p9cal_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // Calibration words widened to 32 bits
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, tcal_r[15:0]};
  assign t2 = {{16{tcal_r[31]}}, tcal_r[31:16]};
  assign t3 = {{16{tcal_r[47]}}, tcal_r[47:32]};
  assign p1 = {16'd0, plow_r[15:0]};
  assign p2 = {{16{plow_r[31]}}, plow_r[31:16]};
  assign p3 = {{16{plow_r[47]}}, plow_r[47:32]};
  assign p4 = {{16{plow_r[63]}}, plow_r[63:48]};
  assign p5 = {{16{phigh_r[15]}}, phigh_r[15:0]};
  assign p6 = {{16{phigh_r[31]}}, phigh_r[31:16]};
  assign p7 = {{16{phigh_r[47]}}, phigh_r[47:32]};
  assign p8 = {{16{phigh_r[63]}}, phigh_r[63:48]};
  assign p9 = {{16{p9cal_r[15]}}, p9cal_r};

  // One enable moves every stage; the last stage is the output register.
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  logic [31:0] adc_t, adc_p;
  assign adc_t = {12'd0, in_tdata[19:0]};
  assign adc_p = {12'd0, in_tdata[39:20]};

  // Stage 1: first temperature products
  logic        v1_r;
  logic [31:0] ta1_r, dd1_r, ap1_r;
  logic [31:0] ta1_nxt, d1, dd1_nxt;
  assign ta1_nxt = 32'($signed(((adc_t >> 3) - (t1 << 1)) * t2) >>> 11);
  assign d1      = (adc_t >> 4) - t1;
  assign dd1_nxt = 32'($signed(d1 * d1) >>> 12);

  // Stage 2: fine temperature
  logic        v2_r;
  logic [31:0] fine2_r, ap2_r;
  logic [31:0] tb2;
  assign tb2 = 32'($signed(dd1_r * t3) >>> 14);

  // Stage 3: centidegrees, pressure offset and the square of its quarter
  logic        v3_r;
  logic [31:0] fine3_r, centi3_r, pa3_r, qq3_r, ap3_r;
  logic [31:0] c5, pa_nxt, q3;
  assign c5     = (fine2_r << 2) + fine2_r + 32'd128;
  assign pa_nxt = 32'($signed(fine2_r) >>> 1) - 32'd64000;
  assign q3     = 32'($signed(pa_nxt) >>> 2);

  // Stage 4: four independent products
  logic        v4_r;
  logic [31:0] fine4_r, centi4_r, ap4_r, m6_r, m5_r, m3_r, m2_r;

  // Stage 5: sums of the divisor and numerator terms
  logic        v5_r;
  logic [31:0] fine5_r, centi5_r, ap5_r, b5_r, a5_r;
  logic [31:0] b5s, b5_nxt, a5_nxt;
  assign b5s    = m6_r + (m5_r << 1);
  assign b5_nxt = 32'($signed(b5s) >>> 2) + (p4 << 16);
  assign a5_nxt = 32'($signed(32'($signed(m3_r) >>> 3) + 32'($signed(m2_r) >>> 1)) >>> 18);

  // Stage 6: divisor and reduced reading
  logic        v6_r;
  logic [31:0] fine6_r, centi6_r, div6_r, num6_r;
  logic [31:0] div6_nxt, num6_nxt;
  assign div6_nxt = 32'($signed((32'd32768 + a5_r) * p1) >>> 15);
  assign num6_nxt = (32'd1048576 - ap5_r) - 32'($signed(b5_r) >>> 12);

  // Stage 7: scaled numerator
  logic        v7_r;
  logic [31:0] fine7_r, centi7_r, div7_r, pm7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ta1_r    <= ta1_nxt;
      dd1_r    <= dd1_nxt;
      ap1_r    <= adc_p;
      fine2_r  <= ta1_r + tb2;
      ap2_r    <= ap1_r;
      fine3_r  <= fine2_r;
      centi3_r <= 32'($signed(c5) >>> 8);
      pa3_r    <= pa_nxt;
      qq3_r    <= q3 * q3;
      ap3_r    <= ap2_r;
      fine4_r  <= fine3_r;
      centi4_r <= centi3_r;
      ap4_r    <= ap3_r;
      m6_r     <= 32'($signed(qq3_r) >>> 11) * p6;
      m5_r     <= pa3_r * p5;
      m3_r     <= p3 * 32'($signed(qq3_r) >>> 13);
      m2_r     <= p2 * pa3_r;
      fine5_r  <= fine4_r;
      centi5_r <= centi4_r;
      ap5_r    <= ap4_r;
      b5_r     <= b5_nxt;
      a5_r     <= a5_nxt;
      fine6_r  <= fine5_r;
      centi6_r <= centi5_r;
      div6_r   <= div6_nxt;
      num6_r   <= num6_nxt;
      fine7_r  <= fine6_r;
      centi7_r <= centi6_r;
      div7_r   <= div6_r;
      pm7_r    <= num6_r * 32'd3125;
    end
  end

  // Large numerators are divided first and doubled afterwards.
  logic              post7;
  logic [31:0]       dvd7;
  logic [SIDE_W-1:0] side7, side_d;
  logic              vd;
  logic [31:0]       quo_d;
  assign post7 = pm7_r[31];
  assign dvd7  = post7 ? pm7_r : (pm7_r << 1);
  assign side7 = {fine7_r, centi7_r, (div7_r == 32'd0), post7};

  ptc_div #(
    .W  (WORD_W),
    .SW (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v7_r),
    .dividend  (dvd7),
    .divisor   (div7_r),
    .side_in   (side7),
    .out_valid (vd),
    .quotient  (quo_d),
    .side_out  (side_d)
  );

  // Stage A: pressure estimate and its correction products
  logic        va_r, inva_r;
  logic [31:0] finea_r, centia_r, pa_r, qsa_r, m8a_r;
  logic [31:0] pest, pq3;
  assign pest = side_d[0] ? (quo_d << 1) : quo_d;
  assign pq3  = pest >> 3;

  // Stage B: scaled corrections
  logic        vb_r, invb_r;
  logic [31:0] fineb_r, centib_r, pb_r, cab_r, cbb_r;

  // Stage C: output register
  logic        vc_r, invc_r;
  logic [31:0] finec_r, centic_r, pc_r;
  logic [31:0] corr;
  assign corr = cab_r + cbb_r + p7;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (adv) begin
      va_r <= vd;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      finea_r  <= side_d[SIDE_W-1 -: WORD_W];
      centia_r <= side_d[WORD_W+1 -: WORD_W];
      inva_r   <= side_d[1];
      pa_r     <= pest;
      qsa_r    <= pq3 * pq3;
      m8a_r    <= (pest >> 2) * p8;
      fineb_r  <= finea_r;
      centib_r <= centia_r;
      invb_r   <= inva_r;
      pb_r     <= pa_r;
      cab_r    <= 32'($signed(p9 * (qsa_r >> 13)) >>> 12);
      cbb_r    <= 32'($signed(m8a_r) >>> 13);
      finec_r  <= fineb_r;
      centic_r <= centib_r;
      invc_r   <= invb_r;
      pc_r     <= invb_r ? 32'd0 : (pb_r + 32'($signed(corr) >>> 4));
    end
  end

  assign out_tvalid   = vc_r;
  assign out_tdata    = {pc_r, centic_r, finec_r};
  assign out_tuser[0] = invc_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[95:64] == 32'd0)
    else $error("invalid pressure result is not zero");

  a_centi_matches_fine: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:32] ==
      32'($signed(out_tdata[31:0] * 32'd5 + 32'd128) >>> 8))
    else $error("temperature fields out of alignment");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
